/* hw/rtl/efcd_pkg.sv */
// efcd_pkg: request types, frame constants and the CRC-8 byte update
// for the encoder frame deframer. No dependencies.
`default_nettype none

package efcd_pkg;

  localparam logic [7:0] StxByte     = 8'h02;
  localparam logic [7:0] EtxByte     = 8'h03;
  localparam logic [7:0] CrcPolyRefl = 8'h8C;
  localparam logic [3:0] CrcBytePos  = 4'd9;
  localparam logic [3:0] LastBytePos = 4'd10;
  localparam logic [3:0] FirstSpdPos = 4'd1;
  localparam logic [3:0] LastSpdPos  = 4'd8;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_NO_STX = 2'd1,
    STATUS_NO_ETX = 2'd2,
    STATUS_CRC    = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_first;
    logic [1:0] speed_slot;
  } in_req_t;

  typedef struct packed {
    status_e            frame_status;
    logic signed [31:0] speed_first;
    logic signed [31:0] speed_second;
    logic [1:0]         slot_out;
  } out_req_t;

  // Dallas/Maxim CRC-8, reflected, one byte.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPolyRefl;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/encoder_frame_crc_deframer_unit.sv */
// encoder_frame_crc_deframer_unit: top level; input register, frame core, result register.
// Path: a byte accepted into the input register is processed by the core and its result is held in the result register.
// Throughput: one byte per cycle while the output is not stalled; the CRC-8 update in the core is combinational.
// The result register frees its slot in the same cycle the request is taken.
// Reset (rst_ni, async, low) empties both registers and idles the frame tracker.
// Depends on efcd_pkg, efcd_in_reg, efcd_core.
`default_nettype none

module encoder_frame_crc_deframer_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire efcd_pkg::in_req_t   in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output efcd_pkg::out_req_t      out_req_o
);

  logic               hold_valid;
  efcd_pkg::in_req_t  hold_req;
  logic               advance;
  logic               res_valid;
  efcd_pkg::out_req_t res;
  logic               out_valid_q;
  efcd_pkg::out_req_t out_req_q;

  assign advance = hold_valid && (!out_valid_q || !out_stall_i);

  efcd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .advance_i    (advance),
    .hold_valid_o (hold_valid),
    .hold_req_o   (hold_req)
  );

  efcd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .req_i       (hold_req),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_req_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

`default_nettype wire

/* hw/rtl/efcd_in_reg.sv */
// efcd_in_reg: input request register with valid/stall handshake.
// Depends on efcd_pkg.
`default_nettype none

module efcd_in_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire efcd_pkg::in_req_t in_req_i,
  input  wire logic             advance_i,
  output logic                  hold_valid_o,
  output efcd_pkg::in_req_t     hold_req_o
);

  logic              valid_q;
  efcd_pkg::in_req_t req_q;
  logic              accept;

  assign in_stall_o   = valid_q && !advance_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign hold_valid_o = valid_q;
  assign hold_req_o   = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/efcd_core.sv */
// efcd_core: frame tracking state, running CRC and result build.
// Depends on efcd_pkg.
`default_nettype none

module efcd_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire efcd_pkg::in_req_t  req_i,
  output logic                   res_valid_o,
  output efcd_pkg::out_req_t     res_o
);

  logic [3:0]  pos_q, pos_d;
  logic        active_q, active_d;
  logic        stx_ok_q, stx_ok_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  rx_crc_q, rx_crc_d;
  logic [63:0] shift_q, shift_d;
  logic [1:0]  slot_q, slot_d;
  logic        in_payload;

  assign in_payload = (pos_q >= efcd_pkg::FirstSpdPos) && (pos_q <= efcd_pkg::LastSpdPos);

  always_comb begin
    pos_d       = pos_q;
    active_d    = active_q;
    stx_ok_d    = stx_ok_q;
    crc_d       = crc_q;
    rx_crc_d    = rx_crc_q;
    shift_d     = shift_q;
    slot_d      = slot_q;
    res_valid_o = 1'b0;
    if (fire_i) begin
      if (req_i.frame_first) begin
        active_d = 1'b1;
        stx_ok_d = (req_i.rx_byte == efcd_pkg::StxByte);
        slot_d   = req_i.speed_slot;
        crc_d    = 8'h00;
        rx_crc_d = 8'h00;
        shift_d  = 64'h0;
        pos_d    = 4'd1;
      end else if (active_q) begin
        if (in_payload) begin
          crc_d   = efcd_pkg::crc8_byte(crc_q, req_i.rx_byte);
          shift_d = {shift_q[55:0], req_i.rx_byte};
          pos_d   = pos_q + 4'd1;
        end else if (pos_q == efcd_pkg::CrcBytePos) begin
          rx_crc_d = req_i.rx_byte;
          pos_d    = pos_q + 4'd1;
        end else if (pos_q == efcd_pkg::LastBytePos) begin
          res_valid_o = 1'b1;
          active_d    = 1'b0;
          pos_d       = 4'd0;
        end else begin
          active_d = 1'b0;
          pos_d    = 4'd0;
        end
      end
    end
  end

  always_comb begin
    priority if (!stx_ok_q) begin
      res_o.frame_status = efcd_pkg::STATUS_NO_STX;
    end else if (req_i.rx_byte != efcd_pkg::EtxByte) begin
      res_o.frame_status = efcd_pkg::STATUS_NO_ETX;
    end else if (rx_crc_q != crc_q) begin
      res_o.frame_status = efcd_pkg::STATUS_CRC;
    end else begin
      res_o.frame_status = efcd_pkg::STATUS_OK;
    end
    res_o.speed_first  = shift_q[63:32];
    res_o.speed_second = shift_q[31:0];
    res_o.slot_out     = slot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 4'd0;
      active_q <= 1'b0;
      stx_ok_q <= 1'b0;
      crc_q    <= 8'h00;
      rx_crc_q <= 8'h00;
      shift_q  <= 64'h0;
      slot_q   <= 2'd0;
    end else begin
      pos_q    <= pos_d;
      active_q <= active_d;
      stx_ok_q <= stx_ok_d;
      crc_q    <= crc_d;
      rx_crc_q <= rx_crc_d;
      shift_q  <= shift_d;
      slot_q   <= slot_d;
    end
  end

endmodule

`default_nettype wire

/* tb/encoder_frame_crc_deframer_unit_test.sv */
// Self-checking bench for encoder_frame_crc_deframer_unit: frames of bytes, good and
// damaged, go through the valid/stall channels and every result is checked against a
// predictor kept here. Depends on efcd_pkg and the unit itself.
`timescale 1ns / 1ps

module encoder_frame_crc_deframer_unit_test;

  localparam int ClkPeriod     = 10;
  localparam int LongHold      = 300;
  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles   = 10;
  localparam int ChunkItems    = 300;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  efcd_pkg::in_req_t  in_req_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  efcd_pkg::out_req_t out_req_o;

  efcd_pkg::in_req_t  byte_queue[$];
  efcd_pkg::out_req_t frame_results_q[$];
  int                 err_count = 0;

  // predictor state
  logic        frm_open = 1'b0;
  logic        stx_good = 1'b0;
  logic [3:0]  next_pos = '0;
  logic [7:0]  crc_run = '0;
  logic [7:0]  crc_got = '0;
  logic [63:0] spd_shift = '0;
  logic [1:0]  slot_held = '0;

  // driver / receiver bookkeeping
  bit       req_taken = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       hold_asked = 0;
  int       hold_served = 0;
  int       hold_left = 0;
  int       mode_left = 0;
  int       pattern_cnt = 0;
  rx_mode_e rx_mode = RX_FLOW;

  encoder_frame_crc_deframer_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // bit-serial form of the reflected Maxim CRC-8
  function automatic logic [7:0] maxim_crc_step(input logic [7:0] acc, input logic [7:0] d);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ efcd_pkg::CrcPolyRefl;
      end
    end
    return r;
  endfunction

  function automatic void track_frame_byte(input efcd_pkg::in_req_t r);
    efcd_pkg::out_req_t res;
    if (r.frame_first) begin
      frm_open  = 1'b1;
      stx_good  = (r.rx_byte == efcd_pkg::StxByte);
      slot_held = r.speed_slot;
      crc_run   = '0;
      crc_got   = '0;
      spd_shift = '0;
      next_pos  = 4'd1;
    end else if (frm_open) begin
      if (next_pos <= efcd_pkg::LastSpdPos) begin
        crc_run   = maxim_crc_step(crc_run, r.rx_byte);
        spd_shift = {spd_shift[55:0], r.rx_byte};
        next_pos  = next_pos + 4'd1;
      end else if (next_pos == efcd_pkg::CrcBytePos) begin
        crc_got  = r.rx_byte;
        next_pos = next_pos + 4'd1;
      end else begin
        if (!stx_good) begin
          res.frame_status = efcd_pkg::STATUS_NO_STX;
        end else if (r.rx_byte != efcd_pkg::EtxByte) begin
          res.frame_status = efcd_pkg::STATUS_NO_ETX;
        end else if (crc_got != crc_run) begin
          res.frame_status = efcd_pkg::STATUS_CRC;
        end else begin
          res.frame_status = efcd_pkg::STATUS_OK;
        end
        res.speed_first  = spd_shift[63:32];
        res.speed_second = spd_shift[31:0];
        res.slot_out     = slot_held;
        frame_results_q.push_back(res);
        frm_open = 1'b0;
        next_pos = '0;
      end
    end
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic first,
                                   input logic [1:0] slot);
    efcd_pkg::in_req_t r;
    r.rx_byte     = b;
    r.frame_first = first;
    r.speed_slot  = slot;
    byte_queue.push_back(r);
  endfunction

  // cut from 1 to 10 sends only the first cut bytes, any other value sends all 11
  function automatic int push_frame(input logic [1:0] slot, input logic [31:0] s1,
                                    input logic [31:0] s2, input bit no_stx,
                                    input bit no_etx, input bit crc_bad, input int cut);
    logic [7:0]  fb[11];
    logic [63:0] spd;
    logic [7:0]  crc;
    int          n;
    spd = {s1, s2};
    crc = '0;
    fb[0] = efcd_pkg::StxByte;
    if (no_stx) begin
      fb[0] = 8'($urandom_range(0, 255));
      if (fb[0] == efcd_pkg::StxByte) begin
        fb[0] = fb[0] ^ 8'h80;
      end
    end
    for (int i = 1; i <= 8; i++) begin
      fb[i] = spd[63 - 8 * (i - 1) -: 8];
      crc   = maxim_crc_step(crc, fb[i]);
    end
    fb[9]  = crc_bad ? (crc ^ 8'($urandom_range(1, 255))) : crc;
    fb[10] = efcd_pkg::EtxByte;
    if (no_etx) begin
      fb[10] = 8'($urandom_range(0, 255));
      if (fb[10] == efcd_pkg::EtxByte) begin
        fb[10] = fb[10] ^ 8'h40;
      end
    end
    n = (cut > 0 && cut < 11) ? cut : 11;
    for (int i = 0; i < n; i++) begin
      add_byte(fb[i], i == 0, (i == 0) ? slot : 2'($urandom_range(0, 3)));
    end
    return n;
  endfunction

  function automatic logic [31:0] pick_speed();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'($urandom);
    endcase
  endfunction

  // one random unit: mostly well-formed frames, some damaged, cut or stray bytes
  function automatic int push_random_unit();
    case ($urandom_range(0, 19))
      0, 1: begin
        add_byte(8'($urandom_range(0, 255)), 1'b0, 2'($urandom_range(0, 3)));
        return 0;
      end
      2, 3: begin
        return push_frame(2'($urandom_range(0, 3)), pick_speed(), pick_speed(),
                          $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0,
                          $urandom_range(0, 5) == 0, $urandom_range(1, 10));
      end
      4: begin
        add_byte(8'($urandom_range(0, 255)), 1'b1, 2'($urandom_range(0, 3)));
        return 1;
      end
      default: begin
        return push_frame(2'($urandom_range(0, 3)), pick_speed(), pick_speed(),
                          $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                          $urandom_range(0, 7) == 0, 0);
      end
    endcase
  endfunction

  task automatic wait_drained();
    while (byte_queue.size() != 0 || in_valid_i || frame_results_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // input side: accepted request feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      track_frame_byte(in_req_i);
      req_taken = 1'b1;
    end
  end

  // driver: bursts of requests with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        in_req_i   <= byte_queue.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // receiver: stall pattern mode is picked anew at random when it runs out; long hold on request
  always @(negedge clk_i) begin
    if (hold_served != hold_asked) begin
      hold_served++;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FLOW: begin
          out_stall_i <= 1'b0;
        end
        RX_COIN: begin
          out_stall_i <= 1'($urandom_range(0, 1));
        end
        RX_PERIODIC: begin
          pattern_cnt++;
          out_stall_i <= (pattern_cnt % 3 == 0);
        end
        default: begin
          out_stall_i <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin : result_check
    efcd_pkg::out_req_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_results_q.size() == 0) begin
        $error("unexpected result: frame_status %0d slot_out %0d",
               out_req_o.frame_status, out_req_o.slot_out);
        err_count++;
      end else begin
        want = frame_results_q.pop_front();
        if (out_req_o.frame_status !== want.frame_status) begin
          $error("frame_status: expected %0d, got %0d", want.frame_status,
                 out_req_o.frame_status);
          err_count++;
        end
        if (out_req_o.speed_first !== want.speed_first) begin
          $error("speed_first: expected %0d, got %0d", want.speed_first,
                 out_req_o.speed_first);
          err_count++;
        end
        if (out_req_o.speed_second !== want.speed_second) begin
          $error("speed_second: expected %0d, got %0d", want.speed_second,
                 out_req_o.speed_second);
          err_count++;
        end
        if (out_req_o.slot_out !== want.slot_out) begin
          $error("slot_out: expected %0d, got %0d", want.slot_out, out_req_o.slot_out);
          err_count++;
        end
      end
    end
  end

  // watchdog: cycles without progress while work is outstanding
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (byte_queue.size() == 0 && !in_valid_i && frame_results_q.size() == 0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("encoder_frame_crc_deframer_unit test failed");
    $finish;
  end

  initial begin : stimulus
    int counted;
    int unused;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // stray bytes while idle
    add_byte(8'h00, 1'b0, 2'd1);
    add_byte(8'hFF, 1'b0, 2'd2);
    // restart mid-frame drops the partial frame
    unused = push_frame(2'd2, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1'b0, 1'b0, 3);
    unused = push_frame(2'd3, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 0);
    // trailing byte after the last one is ignored
    add_byte(8'h02, 1'b0, 2'd3);
    // all three faults: missing STX wins; speeds still decoded
    unused = push_frame(2'd0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 0);
    // missing ETX wins over bad CRC
    unused = push_frame(2'd1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 0);
    unused = push_frame(2'd2, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 0);
    wait_drained();

    for (int chunk = 0; chunk < 4; chunk++) begin
      if (chunk == 1) begin
        hold_asked++;
      end
      counted = 0;
      while (counted < ChunkItems) begin
        counted += push_random_unit();
      end
      if (chunk == 2) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("encoder_frame_crc_deframer_unit test passed");
    end else begin
      $display("encoder_frame_crc_deframer_unit test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/efcd_pkg.sv
hw/rtl/efcd_in_reg.sv
hw/rtl/efcd_core.sv
hw/rtl/encoder_frame_crc_deframer_unit.sv
tb/encoder_frame_crc_deframer_unit_test.sv
